>>> sv/bhq_pkg.sv
`timescale 1ns / 1ps

package bhq_pkg;

    // field widths of the request and response transfers
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 10;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 11;

    // default heap storage and reset capacity
    localparam int HEAP_DEPTH = 1024;
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    // extreme key values
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_DEC   = 3'd4;

endpackage

>>> sv/bhq_if.sv
`timescale 1ns / 1ps

// request channel: one command per transfer
interface bhq_req_if import bhq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key_value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output cmd, output key_value, output position, input ready);
    modport sink   (input valid, input cmd, input key_value, input position, output ready);
endinterface

// response channel: one result per request
interface bhq_rsp_if import bhq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] extracted;
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] min_key;
    logic [CNT_W-1:0]        count;

    modport source (output valid, output extracted, output status, output min_key,
                    output count, input ready);
    modport sink   (input valid, input extracted, input status, input min_key,
                    input count, output ready);
endinterface

>>> sv/bhq_mem.sv
`timescale 1ns / 1ps

module bhq_mem import bhq_pkg::*; #(
    parameter int DEPTH = HEAP_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [KEY_W-1:0] wdata,
    input  logic [AW-1:0]           raddr,
    output logic signed [KEY_W-1:0] rdata
);

    logic signed [KEY_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/binary_min_heap_queue.sv
`timescale 1ns / 1ps

// Binary min-heap priority queue of signed 32-bit keys.
// req carries cmd (insert, extract minimum, decrease key, delete at index),
// key_value and position; rsp returns extracted, status, min_key and count,
// exactly one response per request, in order.
// cfg_wr_en / cfg_wr_data set the capacity limit; write it only while idle.
// One request is worked at a time; req.ready is high only while idle.
// A rejected command goes straight to the response, and a decrease that does
// not lower the key is turned back after one read of the stored key. Insert,
// decrease and the first half of delete walk upward a heap level at a time
// (one read of the parent, one compare and write back); extract and the second
// half of delete walk downward a level at a time (two child reads from the
// single read port of the heap memory, then compare and write back).
// The response is held in an output register; if the receiver stalls, the
// next request is still accepted and worked, and waits before its response.
// Reset empties the heap (no memory clearing pass) and sets the capacity to 1024.
module binary_min_heap_queue import bhq_pkg::*; #(
    parameter int DEPTH = HEAP_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    bhq_req_if.sink          req,
    bhq_rsp_if.source        rsp,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = AW + 2;
    localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC_CHK = 4'd1;
    localparam logic [3:0] S_SU_RD   = 4'd2;
    localparam logic [3:0] S_SU_CMP  = 4'd3;
    localparam logic [3:0] S_TAKE    = 4'd4;
    localparam logic [3:0] S_LAST    = 4'd5;
    localparam logic [3:0] S_SD_RL   = 4'd6;
    localparam logic [3:0] S_SD_RR   = 4'd7;
    localparam logic [3:0] S_SD_CMP  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]        cap_reg, cap_next;
    logic                    del_reg, del_next;
    logic                    out_valid_reg, out_valid_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] root_reg, root_next;
    logic signed [KEY_W-1:0] lval_reg, lval_next;
    logic                    rvalid_reg, rvalid_next;
    logic signed [KEY_W-1:0] ext_reg, ext_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;
    logic signed [KEY_W-1:0] out_ext_reg, out_ext_next;
    logic [STAT_W-1:0]       out_stat_reg, out_stat_next;
    logic signed [KEY_W-1:0] out_min_reg, out_min_next;
    logic [CNT_W-1:0]        out_cnt_reg, out_cnt_next;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic signed [KEY_W-1:0] mem_rdata;

    logic [CMPW-1:0]         count_cmp;
    logic [CMPW-1:0]         cap_eff;
    logic [CMPW-1:0]         pos_cmp;
    logic [IW-1:0]           count_x;
    logic [IW-1:0]           lchild;
    logic [IW-1:0]           rchild;
    logic [AW-1:0]           parent;
    logic [AW-1:0]           last_addr;
    logic [AW-1:0]           best_idx;
    logic signed [KEY_W-1:0] best_val;
    logic                    best_moved;

    bhq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // index arithmetic
    assign count_cmp = CMPW'(count_reg);
    assign cap_eff   = (CMPW'(cap_reg) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap_reg);
    assign pos_cmp   = CMPW'(req.position);
    assign count_x   = IW'(count_reg);
    assign lchild    = IW'({idx_reg, 1'b1});
    assign rchild    = lchild + IW'(1);
    assign parent    = AW'((idx_reg - AW'(1)) >> 1);
    assign last_addr = AW'(count_reg - CW'(1));

    // smallest of the moving key and its children
    always_comb
    begin
        best_idx   = idx_reg;
        best_val   = key_reg;
        best_moved = 1'b0;
        if (lval_reg < key_reg)
        begin
            best_idx   = lchild[AW-1:0];
            best_val   = lval_reg;
            best_moved = 1'b1;
        end
        if (rvalid_reg && (mem_rdata < best_val))
        begin
            best_idx   = rchild[AW-1:0];
            best_val   = mem_rdata;
            best_moved = 1'b1;
        end
    end

    assign req.ready = (state_reg == S_IDLE);

    // command sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        del_next       = del_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        root_next      = root_reg;
        lval_next      = lval_reg;
        rvalid_next    = rvalid_reg;
        ext_next       = ext_reg;
        stat_next      = stat_reg;
        out_ext_next   = out_ext_reg;
        out_stat_next  = out_stat_reg;
        out_min_next   = out_min_reg;
        out_cnt_next   = out_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = key_reg;
        mem_raddr      = idx_reg;

        if (cfg_wr_en)
        begin
            cap_next = cfg_wr_data;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next  = req.key_value;
                    del_next  = 1'b0;
                    ext_next  = '0;
                    stat_next = ST_OK;
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (count_cmp >= cap_eff)
                            begin
                                stat_next  = ST_OVERFLOW;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                state_next = S_SU_RD;
                            end
                        end
                        CMD_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                ext_next   = KEY_MAX;
                                stat_next  = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ext_next   = root_reg;
                                state_next = S_TAKE;
                            end
                        end
                        CMD_DECREASE:
                        begin
                            if (pos_cmp >= count_cmp)
                            begin
                                stat_next  = ST_BAD_INDEX;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                mem_raddr  = AW'(req.position);
                                idx_next   = AW'(req.position);
                                state_next = S_DEC_CHK;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_cmp >= count_cmp)
                            begin
                                stat_next  = ST_BAD_INDEX;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = AW'(req.position);
                                key_next   = KEY_MIN;
                                del_next   = 1'b1;
                                state_next = S_SU_RD;
                            end
                        end
                    endcase
                end
            end

            // stored key at the position is in mem_rdata
            S_DEC_CHK:
            begin
                if (key_reg >= mem_rdata)
                begin
                    stat_next  = ST_NOT_DEC;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SU_RD;
                end
            end

            // sift up: fetch the parent or settle at the root
            S_SU_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = del_reg ? S_TAKE : S_DONE;
                end
                else
                begin
                    mem_raddr  = parent;
                    state_next = S_SU_CMP;
                end
            end

            S_SU_CMP:
            begin
                mem_we = 1'b1;
                if (mem_rdata <= key_reg)
                begin
                    state_next = del_reg ? S_TAKE : S_DONE;
                end
                else
                begin
                    mem_wdata  = mem_rdata;
                    idx_next   = parent;
                    state_next = S_SU_RD;
                end
            end

            // remove the root, fetch the last entry to refill it
            S_TAKE:
            begin
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = last_addr;
                    state_next = S_LAST;
                end
            end

            S_LAST:
            begin
                key_next   = mem_rdata;
                idx_next   = '0;
                state_next = S_SD_RL;
            end

            // sift down: fetch the left child or settle here
            S_SD_RL:
            begin
                if (lchild >= count_x)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = lchild[AW-1:0];
                    state_next = S_SD_RR;
                end
            end

            S_SD_RR:
            begin
                lval_next = mem_rdata;
                if (rchild < count_x)
                begin
                    mem_raddr   = rchild[AW-1:0];
                    rvalid_next = 1'b1;
                end
                else
                begin
                    rvalid_next = 1'b0;
                end
                state_next = S_SD_CMP;
            end

            S_SD_CMP:
            begin
                mem_we = 1'b1;
                if (best_moved)
                begin
                    mem_wdata  = best_val;
                    idx_next   = best_idx;
                    state_next = S_SD_RL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // load the response register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ext_next   = ext_reg;
                    out_stat_next  = stat_reg;
                    out_min_next   = (count_reg != '0) ? root_reg : '0;
                    out_cnt_next   = CNT_W'(count_cmp);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // root mirror follows every write to entry zero
        if (mem_we && (mem_waddr == '0))
        begin
            root_next = mem_wdata;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            del_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            del_reg       <= del_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        root_reg     <= root_next;
        lval_reg     <= lval_next;
        rvalid_reg   <= rvalid_next;
        ext_reg      <= ext_next;
        stat_reg     <= stat_next;
        out_ext_reg  <= out_ext_next;
        out_stat_reg <= out_stat_next;
        out_min_reg  <= out_min_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.extracted = out_ext_reg;
    assign rsp.status    = out_stat_reg;
    assign rsp.min_key   = out_min_reg;
    assign rsp.count     = out_cnt_reg;

    // count never exceeds the storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMPW'(count_reg) <= CMPW'(DEPTH))
        else $error("heap count beyond storage");

    // heap writes stay inside the live entries
    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (IW'(mem_waddr) < count_x))
        else $error("heap write outside live entries");

    // a finished result waits while the response is stalled
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("result lost under response stall");

    // an empty response always reports a zero count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg == ST_EMPTY) |-> (out_cnt_reg == '0))
        else $error("empty status with nonzero count");

endmodule
